// File: design/mrp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mrp_pkg;

  // Relocation type codes carried in the raw type word.
  localparam logic [31:0] TYPE_WORD32 = 32'd2;
  localparam logic [31:0] TYPE_JUMP26 = 32'd4;
  localparam logic [31:0] TYPE_HI16   = 32'd5;
  localparam logic [31:0] TYPE_LO16   = 32'd6;

  // Field widths of the patched instruction forms.
  localparam int JUMP_BITS = 26;
  localparam int HALF_BITS = 16;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_LOAD_BASE     = 2'd0,
    CFG_SECTION_START = 2'd1,
    CFG_SECTION_SIZE  = 2'd2
  } cfg_idx_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_PATCHED        = 3'd0,
    ST_HI_HELD        = 3'd1,
    ST_OUT_OF_SECTION = 3'd2,
    ST_LO_UNMATCHED   = 3'd3,
    ST_UNKNOWN        = 3'd4
  } status_t;

  // Work the back end carries out for one record.
  typedef enum logic [1:0] {
    OP_NOWRITE = 2'd0,
    OP_WORD32  = 2'd1,
    OP_JUMP26  = 2'd2,
    OP_LO16    = 2'd3
  } op_t;

  // Beat position within a record that produces two results.
  typedef enum logic {
    PH_FIRST  = 1'b0,
    PH_SECOND = 1'b1
  } phase_t;

  // One classified record, as passed from the front end to the back end.
  typedef struct packed {
    op_t         op;
    status_t     status;
    logic [31:0] offset;
    logic [31:0] word;
    logic [31:0] hi_offset;
    logic [31:0] hi_word;
  } job_t;

endpackage

`default_nettype wire

// File: design/mrp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module mrp_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [31:0]   section_start,
  input  wire logic [31:0]   section_size,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          in_new_section,
  input  wire logic [31:0]   in_record_offset,
  input  wire logic [31:0]   in_reloc_type,
  input  wire logic [31:0]   in_target_word,
  input  wire logic          q_ready,
  output logic               q_push,
  output mrp_pkg::job_t      q_job
);
  import mrp_pkg::*;

  logic        hi_pending_r;
  logic        hi_pending_nxt;
  logic [31:0] hi_offset_r;
  logic [31:0] hi_word_r;
  logic        hi_load;
  logic        accept;
  logic        pend_eff;
  logic [31:0] rebased;
  logic        in_section;

  assign in_ready = q_ready;
  assign accept   = in_valid & q_ready;
  assign q_push   = accept;

  // Rebase the offset, check the section bound and classify the record.
  always_comb begin
    rebased        = in_record_offset - section_start;
    in_section     = rebased < section_size;
    pend_eff       = hi_pending_r & ~in_new_section;
    hi_pending_nxt = accept ? pend_eff : hi_pending_r;
    hi_load        = 1'b0;

    q_job.op        = OP_NOWRITE;
    q_job.status    = ST_OUT_OF_SECTION;
    q_job.offset    = rebased;
    q_job.word      = in_target_word;
    q_job.hi_offset = hi_offset_r;
    q_job.hi_word   = hi_word_r;

    if (in_section) begin
      case (in_reloc_type)
        TYPE_WORD32: begin
          q_job.op     = OP_WORD32;
          q_job.status = ST_PATCHED;
        end
        TYPE_JUMP26: begin
          q_job.op     = OP_JUMP26;
          q_job.status = ST_PATCHED;
        end
        TYPE_HI16: begin
          q_job.status = ST_HI_HELD;
          hi_load      = accept;
          if (accept) begin
            hi_pending_nxt = 1'b1;
          end
        end
        TYPE_LO16: begin
          if (pend_eff) begin
            q_job.op     = OP_LO16;
            q_job.status = ST_PATCHED;
          end else begin
            q_job.status = ST_LO_UNMATCHED;
          end
          if (accept) begin
            hi_pending_nxt = 1'b0;
          end
        end
        default: begin
          q_job.status = ST_UNKNOWN;
        end
      endcase
    end
  end

  // Pending flag for a held HI16 record.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_pending_r <= 1'b0;
    end else begin
      hi_pending_r <= hi_pending_nxt;
    end
  end

  // Held HI16 location and word; only read while the pending flag is set.
  always_ff @(posedge clk) begin
    if (hi_load) begin
      hi_offset_r <= rebased;
      hi_word_r   <= in_target_word;
    end
  end

endmodule

`default_nettype wire

// File: design/mrp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module mrp_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire mrp_pkg::job_t push_job,
  output logic               ready,
  input  wire logic          pop,
  output logic               head_valid,
  output mrp_pkg::job_t      head_job
);
  import mrp_pkg::*;

  job_t       slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       do_pop;

  assign ready      = count_r != 2'd2;
  assign head_valid = count_r != 2'd0;
  assign head_job   = slot_r[rd_ptr_r];
  assign do_pop     = pop & head_valid;

  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

// File: design/mrp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module mrp_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [31:0]   load_base,
  input  wire logic          head_valid,
  input  wire mrp_pkg::job_t head_job,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               out_write_enable,
  output logic [31:0]        out_patch_offset,
  output logic [31:0]        out_patch_word,
  output logic [2:0]         out_status,
  output logic               out_last
);
  import mrp_pkg::*;

  phase_t                 phase_r;
  phase_t                 phase_nxt;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic                   load;
  logic                   we_nxt;
  logic [31:0]            off_nxt;
  logic [31:0]            word_nxt;
  status_t                status_nxt;
  logic                   last_nxt;
  logic                   we_r;
  logic [31:0]            off_r;
  logic [31:0]            word_r;
  status_t                status_r;
  logic                   last_r;
  logic [31:0]            lo_sext;
  logic [31:0]            lo_sum;
  logic [HALF_BITS-1:0]   hi_half;
  logic [JUMP_BITS-1:0]   jump_field;

  assign load = head_valid & (~out_valid_r | out_ready);

  // Patch arithmetic for the record at the queue head.
  always_comb begin
    lo_sext    = {{HALF_BITS{head_job.word[HALF_BITS-1]}}, head_job.word[HALF_BITS-1:0]};
    lo_sum     = {head_job.hi_word[HALF_BITS-1:0], {HALF_BITS{1'b0}}} + lo_sext + load_base;
    hi_half    = lo_sum[31:HALF_BITS] + {{(HALF_BITS-1){1'b0}}, lo_sum[HALF_BITS-1]};
    jump_field = head_job.word[JUMP_BITS-1:0] + load_base[JUMP_BITS+1:2];
  end

  // Beat sequencing and result selection.
  always_comb begin
    phase_nxt     = phase_r;
    pop           = 1'b0;
    out_valid_nxt = out_valid_r & ~out_ready;
    we_nxt        = 1'b0;
    off_nxt       = head_job.offset;
    word_nxt      = '0;
    status_nxt    = head_job.status;
    last_nxt      = 1'b1;

    case (head_job.op)
      OP_WORD32: begin
        we_nxt   = 1'b1;
        word_nxt = head_job.word + load_base;
      end
      OP_JUMP26: begin
        we_nxt   = 1'b1;
        word_nxt = {head_job.word[31:JUMP_BITS], jump_field};
      end
      OP_LO16: begin
        we_nxt = 1'b1;
        if (phase_r == PH_FIRST) begin
          word_nxt = {head_job.word[31:HALF_BITS], lo_sum[HALF_BITS-1:0]};
          last_nxt = 1'b0;
        end else begin
          off_nxt  = head_job.hi_offset;
          word_nxt = {head_job.hi_word[31:HALF_BITS], hi_half};
        end
      end
      default: begin
        we_nxt = 1'b0;
      end
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
      if (head_job.op == OP_LO16 && phase_r == PH_FIRST) begin
        phase_nxt = PH_SECOND;
      end else begin
        phase_nxt = PH_FIRST;
        pop       = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      we_r     <= we_nxt;
      off_r    <= off_nxt;
      word_r   <= word_nxt;
      status_r <= status_nxt;
      last_r   <= last_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_write_enable = we_r;
  assign out_patch_offset = off_r;
  assign out_patch_word   = word_r;
  assign out_status       = status_r;
  assign out_last         = last_r;

endmodule

`default_nettype wire

// File: design/mips_rel_relocation_patcher_core.sv
// A record is written into the queue, and its first result beat is then registered in
// the output register.
// Throughput: one record per cycle unless out_ready or a full queue stalls; a matched
// LO16 record's two result beats leave through the single output register one per cycle.
// Reset (synchronous, active low) clears the held HI16 flag, the queue, the output
// stage and the three configuration registers to zero.
`timescale 1ns / 1ps
`default_nettype none

module mips_rel_relocation_patcher_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_new_section,
  input  wire logic [31:0] in_record_offset,
  input  wire logic [31:0] in_reloc_type,
  input  wire logic [31:0] in_target_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_write_enable,
  output logic [31:0]      out_patch_offset,
  output logic [31:0]      out_patch_word,
  output logic [2:0]       out_status,
  output logic             out_last
);
  import mrp_pkg::*;

  logic [31:0] load_base_r;
  logic [31:0] section_start_r;
  logic [31:0] section_size_r;
  logic        q_ready;
  logic        q_push;
  job_t        q_job;
  logic        head_valid;
  job_t        head_job;
  logic        pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_base_r     <= '0;
      section_start_r <= '0;
      section_size_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LOAD_BASE:     load_base_r     <= cfg_data;
        CFG_SECTION_START: section_start_r <= cfg_data;
        CFG_SECTION_SIZE:  section_size_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front end: rebase, bound check, classify and track the held HI16.
  mrp_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .section_start    (section_start_r),
    .section_size     (section_size_r),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_new_section   (in_new_section),
    .in_record_offset (in_record_offset),
    .in_reloc_type    (in_reloc_type),
    .in_target_word   (in_target_word),
    .q_ready          (q_ready),
    .q_push           (q_push),
    .q_job            (q_job)
  );

  // Two-entry queue between the front and back ends.
  mrp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_job),
    .ready      (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // Back end: patch arithmetic and result beats.
  mrp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .load_base        (load_base_r),
    .head_valid       (head_valid),
    .head_job         (head_job),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_write_enable (out_write_enable),
    .out_patch_offset (out_patch_offset),
    .out_patch_word   (out_patch_word),
    .out_status       (out_status),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire

// File: design/mrp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mrp_port_props (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_write_enable,
  input wire logic [31:0] out_patch_offset,
  input wire logic [31:0] out_patch_word,
  input wire logic [2:0]  out_status,
  input wire logic        out_last
);
  import mrp_pkg::*;

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_patch_offset)
      && $stable(out_patch_word) && $stable(out_status) && $stable(out_last))
    else $error("result beat changed while stalled");

  // Only a patched beat writes, and a beat without a write carries a zero word.
  a_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_PATCHED |-> !out_write_enable && out_patch_word == '0)
    else $error("write or word on a beat that is not patched");

  // Only the first half of a matched LO16 pair is not last.
  a_first_half: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_write_enable && out_status == ST_PATCHED)
    else $error("non-final beat is not a patch");

  // The HI16 half follows the LO16 half on the next cycle.
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && out_last && out_write_enable)
    else $error("second half of a LO16 pair did not follow");

endmodule

bind mips_rel_relocation_patcher_core mrp_port_props u_mrp_port_props (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_write_enable (out_write_enable),
  .out_patch_offset (out_patch_offset),
  .out_patch_word   (out_patch_word),
  .out_status       (out_status),
  .out_last         (out_last)
);

`default_nettype wire
